// ----- rtl/request_timeout_table_top_assert.svh -----
// Assertion macros for the request timeout table.
// Used by the port checker; needs a clk and rst_n in the scope of each use.
`ifndef REQUEST_TIMEOUT_TABLE_TOP_ASSERT_SVH
`define REQUEST_TIMEOUT_TABLE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("request timeout table: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("request timeout table: assertion failed");

`endif

// ----- rtl/rtt_pkg.sv -----
// Shared types and constants for the request timeout table.
// No dependencies; imported by every module of the block.
package rtt_pkg;

  localparam int SLOTS  = 32;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [7:0] CODE_TIMEOUT  = 8'h9A;
  localparam logic [7:0] CODE_CANCEL   = 8'h98;
  localparam logic [7:0] STATUS_FAILED = 8'd2;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } rtt_op_t;

  typedef enum logic [1:0] {
    EV_WAITER   = 2'd0,
    EV_CALLBACK = 2'd1,
    EV_IGNORED  = 2'd2,
    EV_DONE     = 2'd3
  } rtt_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } rtt_state_t;

  typedef struct packed {
    rtt_op_t     op;
    logic [4:0]  slot_index;
    logic [31:0] key;
    logic [7:0]  status;
    logic [31:0] deadline;
    logic        has_waiter;
    logic        has_callback;
    logic [31:0] now;
  } rtt_in_t;

  typedef struct packed {
    rtt_kind_t   event_kind;
    logic [4:0]  slot_number;
    logic [7:0]  error_code;
    logic [31:0] next_deadline;
    logic        deadline_updated;
    logic        last;
  } rtt_out_t;

  // One table entry
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  status;
    logic [31:0] deadline;
    logic        waiter;
    logic        callback;
  } rtt_row_t;

  // Write port of the table: load a row, or drop an entry
  typedef struct packed {
    logic              wen;
    logic              clr;
    logic [SLOT_W-1:0] addr;
    rtt_row_t          row;
  } rtt_wr_t;

  // Verdict of the compare unit on one entry
  typedef struct packed {
    logic      hit;
    logic      match;
    logic      closer;
    rtt_kind_t kind;
  } rtt_eval_t;

endpackage

// ----- rtl/rtt_store.sv -----
// Slot table storage: one row per slot in a memory, plus a valid bit per slot.
// Depends on rtt_pkg. An entry that is not valid reads as all zero.
module rtt_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rtt_pkg::rtt_wr_t           wr,
  input  logic                       rd_en,
  input  logic [rtt_pkg::SLOT_W-1:0] rd_addr,
  output rtt_pkg::rtt_row_t          rd_row
);
  import rtt_pkg::*;

  rtt_row_t             mem [SLOTS];
  logic [SLOTS-1:0]     vld_r;
  rtt_row_t             rd_data_r;
  logic                 rd_vld_r;

  // Write the row array
  always_ff @(posedge clk) begin
    if (wr.wen) begin
      mem[wr.addr] <= wr.row;
    end
  end

  // Track which entries hold written data; reset empties the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.wen) begin
      vld_r[wr.addr] <= 1'b1;
    end else if (wr.clr) begin
      vld_r[wr.addr] <= 1'b0;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Mask entries never written or dropped
  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- rtl/rtt_eval.sv -----
// Shared compare unit: judges one table entry per cycle during a scan.
// Depends on rtt_pkg.
module rtt_eval (
  input  rtt_pkg::rtt_row_t  row,
  input  rtt_pkg::rtt_op_t   op,
  input  logic [31:0]        key,
  input  logic [31:0]        now,
  input  logic [31:0]        best,
  output rtt_pkg::rtt_eval_t res
);
  import rtt_pkg::*;

  logic live;
  logic expired;

  // Compare deadline against now and the running minimum, key against request
  always_comb begin
    live       = (row.status != 8'd0);
    expired    = live && (now >= row.deadline);
    res.match  = (row.key == key);
    res.closer = live && !expired && ((best == 32'd0) || (best > row.deadline));
    res.hit    = (op == OP_CANCEL) ? res.match : expired;
    // Waiter takes precedence over callback
    if (row.waiter) begin
      res.kind = EV_WAITER;
    end else if (row.callback) begin
      res.kind = EV_CALLBACK;
    end else begin
      res.kind = EV_IGNORED;
    end
  end

endmodule

// ----- rtl/request_timeout_table_top.sv -----
// Request timeout table, top level: sequencer around the slot table and compare unit.
// Depends on rtt_pkg, rtt_store and rtt_eval.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   Op write loads one slot at that edge and leaves busy low; unused op 3
//   is taken and does nothing. Neither gives a result.
//   Op expire walks every slot through the one compare unit, one slot per
//   cycle, reading the table through its registered port. Each timed-out
//   slot gives an event; a done result with the next deadline follows.
//   Op cancel walks the slots the same way and stops at the first key match.
//   Results appear on out_data for one cycle with out_valid high; the
//   receiver cannot stall them. last marks the done result.
//   Each result shows in the cycle after it is formed.
//   Reset (synchronous, active low) empties the table at once, zeroes the
//   next deadline and drops any request in flight.
module request_timeout_table_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rtt_pkg::rtt_in_t  in_data,
  output logic              out_valid,
  output rtt_pkg::rtt_out_t out_data
);
  import rtt_pkg::*;

  rtt_state_t        state_r, state_nxt;
  rtt_op_t           op_r, op_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ev_vld_r, ev_vld_nxt;
  logic [SLOT_W-1:0] ev_idx_r, ev_idx_nxt;
  logic [31:0]       best_r, best_nxt;
  logic              ok_r, ok_nxt;
  logic [31:0]       next_due_r, next_due_nxt;
  logic              out_valid_r, out_valid_nxt;
  rtt_out_t          out_data_r, out_data_nxt;

  logic              accept;
  logic              in_range;
  logic              rd_en;
  logic              stop;
  logic              fire;
  logic              expire_ok;
  logic [7:0]        code;
  rtt_wr_t           wr;
  rtt_row_t          rd_row;
  rtt_eval_t         ev;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (int'(in_data.slot_index) < SLOTS);
  assign stop      = ev_vld_r && (op_r == OP_CANCEL) && ev.match;
  assign fire      = ev_vld_r && ev.hit;
  assign rd_en     = (state_r == ST_SCAN) && (cnt_r < CNT_W'(SLOTS)) && !stop;
  assign expire_ok = (op_r == OP_EXPIRE) && ok_r;
  assign code      = (op_r == OP_CANCEL) ? CODE_CANCEL : CODE_TIMEOUT;

  rtt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[SLOT_W-1:0]),
    .rd_row  (rd_row)
  );

  rtt_eval u_eval (
    .row  (rd_row),
    .op   (op_r),
    .key  (key_r),
    .now  (now_r),
    .best (best_r),
    .res  (ev)
  );

  // Table write: load on a write request, mark failed waiters, drop callbacks
  always_comb begin
    wr = '0;
    if (accept && (in_data.op == OP_WRITE) && in_range) begin
      wr.wen          = 1'b1;
      wr.addr         = SLOT_W'(in_data.slot_index);
      wr.row.key      = in_data.key;
      wr.row.status   = in_data.status;
      wr.row.deadline = in_data.deadline;
      wr.row.waiter   = in_data.has_waiter;
      wr.row.callback = in_data.has_callback;
    end else if (fire) begin
      wr.addr = ev_idx_r;
      wr.row  = rd_row;
      if (ev.kind == EV_WAITER) begin
        wr.wen        = 1'b1;
        wr.row.status = STATUS_FAILED;
      end else if (ev.kind == EV_CALLBACK) begin
        wr.clr = 1'b1;
      end
    end
  end

  // Sequencer: start a walk, advance the read pointer, close with a done result
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    now_nxt      = now_r;
    cnt_nxt      = cnt_r;
    ev_vld_nxt   = rd_en;
    ev_idx_nxt   = cnt_r[SLOT_W-1:0];
    best_nxt     = best_r;
    ok_nxt       = ok_r;
    next_due_nxt = next_due_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && ((in_data.op == OP_EXPIRE) || (in_data.op == OP_CANCEL))) begin
          state_nxt = ST_SCAN;
          op_nxt    = in_data.op;
          key_nxt   = in_data.key;
          now_nxt   = in_data.now;
          cnt_nxt   = '0;
          best_nxt  = '0;
          ok_nxt    = 1'b1;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (fire && (op_r == OP_EXPIRE)) begin
          ok_nxt = 1'b0;
        end
        if (ev_vld_r && ev.closer && (op_r == OP_EXPIRE)) begin
          best_nxt = rd_row.deadline;
        end
        // The last slot is judged in the cycle the pointer reaches the end
        if (stop || (cnt_r == CNT_W'(SLOTS))) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (expire_ok) begin
          next_due_nxt = best_r;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Form the next result: an event per hit slot, then the done result
  always_comb begin
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    if (fire) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.event_kind  = ev.kind;
      out_data_nxt.slot_number = 5'(ev_idx_r);
      out_data_nxt.error_code  = code;
    end else if (state_r == ST_DONE) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.event_kind       = EV_DONE;
      out_data_nxt.error_code       = code;
      out_data_nxt.next_deadline    = expire_ok ? best_r : next_due_r;
      out_data_nxt.deadline_updated = expire_ok;
      out_data_nxt.last             = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ev_vld_r    <= 1'b0;
      ok_r        <= 1'b1;
      best_r      <= '0;
      next_due_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ev_vld_r    <= ev_vld_nxt;
      ok_r        <= ok_nxt;
      best_r      <= best_nxt;
      next_due_r  <= next_due_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    ev_idx_r   <= ev_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/rtt_checker.sv -----
// Port checker for the request timeout table, bound to the top level.
// Depends on rtt_pkg and request_timeout_table_top_assert.svh.
`include "request_timeout_table_top_assert.svh"

module rtt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input rtt_pkg::rtt_in_t  in_data,
  input logic              out_valid,
  input rtt_pkg::rtt_out_t out_data
);
  import rtt_pkg::*;

  // Scans and cancels hold the block busy
  `RTT_ASSERT_NEXT(a_scan_busy, start && !busy && ((in_data.op == OP_EXPIRE) || (in_data.op == OP_CANCEL)), busy)

  // Writes and the unused op finish at once
  `RTT_ASSERT_NEXT(a_write_idle, start && !busy && ((in_data.op == OP_WRITE) || (in_data.op == OP_NONE)), !busy)

  // Leaving busy shows the done result
  `RTT_ASSERT_NOW(a_done_at_end, $fell(busy), out_valid && out_data.last)

  // Only the done result carries last and a deadline
  `RTT_ASSERT_NOW(a_event_fields, out_valid && (out_data.event_kind != EV_DONE), !out_data.last && !out_data.deadline_updated && (out_data.next_deadline == 32'd0))

  // Last is the done kind
  `RTT_ASSERT_NOW(a_last_kind, out_valid && out_data.last, out_data.event_kind == EV_DONE)

endmodule

bind request_timeout_table_top rtt_checker u_rtt_checker (.*);
